/* design/bpa_pkg.sv */
// Shared types and codes of the bitmap page allocator.
// Used by bpa_word_eval and bitmap_page_allocator; depends on nothing.
`default_nettype none

package bpa_pkg;

    // Request codes
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_RESERVE = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // Configuration register indexes
    localparam logic [0:0] CFG_BLOCKS_IN_USE = 1'd0;
    localparam logic [0:0] CFG_BASE_ADDRESS  = 1'd1;

    // Size of the managed bitmap; field widths are fixed around this value
    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_SHIFT = 12;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_RUN   = 2'd1,
        STAT_ZERO_LEN = 2'd2,
        STAT_RANGE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_UPDATE,
        S_FINISH
    } state_t;

    // Per-word analysis from the shared scan unit
    typedef struct packed {
        logic       carry_hit;   // run entering the word completes in it
        logic       win_hit;     // a run of the length fits inside the word
        logic [4:0] win_pos;     // lowest start of such a run
        logic       all_free;
        logic [4:0] lead_free;   // free bits at the top of the word
        logic [5:0] resv_cnt;    // reserved bits below the limit
    } word_eval_t;

endpackage

`default_nettype wire

/* design/bpa_if.sv */
// Request and response channel interfaces of the bitmap page allocator.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [10:0] run_length;
    logic [31:0] address;
    logic [9:0]  block_index;

    modport source (output valid, req_type, run_length, address, block_index, input ready);
    modport sink   (input valid, req_type, run_length, address, block_index, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] alloc_address;
    logic [9:0]  first_block;
    logic [10:0] free_count;

    modport source (output valid, status, alloc_address, first_block, free_count, input ready);
    modport sink   (input valid, status, alloc_address, first_block, free_count, output ready);
endinterface

`default_nettype wire

/* design/bitmap_page_allocator.sv */
// Bitmap page allocator top level: sequencer, bitmap memory, config registers.
// Depends on bpa_pkg, bpa_req_if / bpa_rsp_if and bpa_word_eval.
//
// Usage:
//   req channel carries one request item (allocate run, free by address,
//   reserve by block); rsp returns exactly one result item per request.
//   The block takes one request at a time: req.ready is high only while idle.
//   Every request sweeps the bitmap one 32-bit word per cycle through the shared
//   word unit, counting reserved blocks; an allocation also searches for the
//   first free run. One that succeeds then rewrites the words its run spans,
//   one per cycle; a valid free or reserve rewrites one word.
//   An item steps through scan, then fill for a successful allocation or update
//   for a valid free or reserve, then finish, which loads the result into the
//   output slot once the slot is free. The bitmap memory port does one read and
//   one write per cycle. Reset: all blocks free, blocks_in_use = 1024,
//   base_address = 0; the map needs no clearing pass (per-word valid bits).
//   A stalled result holds in the output register; the next item is still
//   accepted and works up to its own result, which waits for the slot.
//   cfg_we writes register cfg_index from cfg_data; the user must write it only
//   while the block is idle, which the block itself does not enforce.
`default_nettype none

module bitmap_page_allocator (
    input  logic        clk,
    input  logic        rst_n,
    bpa_req_if.sink     req,
    bpa_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int MAP_WORDS   = (bpa_pkg::NUM_BLOCKS + 31) / 32;
    localparam int AW          = $clog2(MAP_WORDS);
    localparam int IW          = AW + 1;
    localparam logic [10:0] LIM_MAX = 11'(bpa_pkg::NUM_BLOCKS);

    // configuration
    logic [10:0] blocks_reg;
    logic [31:0] base_reg;
    logic [10:0] limit;
    logic [IW-1:0] nwords;

    // sequencer
    bpa_pkg::state_t state_reg, state_next;

    // item context
    logic [1:0]  req_reg, req_next;
    logic [10:0] len_reg, len_next;
    logic [10:0] tgt_reg, tgt_next;
    logic        tgt_ok_reg, tgt_ok_next;
    logic        search_reg, search_next;
    logic        found_reg, found_next;
    logic [10:0] start_reg, start_next;
    logic [11:0] run_reg, run_next;
    logic [10:0] run_start_reg, run_start_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [31:0] tword_reg, tword_next;

    // word sweep
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] ev_idx_reg, ev_idx_next;

    // bitmap memory
    logic [31:0]          map_mem [MAP_WORDS];
    logic [31:0]          map_q_reg;
    logic [MAP_WORDS-1:0] map_vld_reg;
    logic                 rvld_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [31:0]          mem_wdata;
    logic [AW-1:0]        mem_raddr;

    // output slot
    logic              rsp_valid_reg, rsp_valid_next;
    bpa_pkg::status_t  status_reg, status_next;
    logic [31:0]       addr_out_reg, addr_out_next;
    logic [9:0]        blk_out_reg, blk_out_next;
    logic [10:0]       fc_out_reg, fc_out_next;

    // combinational helpers
    logic        scan_issue;
    logic        fill_issue;
    logic        issue;
    logic        pass_done;
    logic        out_free;
    logic        accept;
    logic        ev_last;
    logic [10:0] end_blk;
    logic [10:0] wbase;
    logic [31:0] rdata;
    logic [31:0] vmask;
    logic [31:0] rview;
    logic [31:0] fmask;
    logic [4:0]  fill_lo;
    logic [4:0]  fill_hi;
    logic [31:0] free_diff;
    logic [19:0] free_blk;
    logic        old_bit;
    logic [11:0] total;
    bpa_pkg::status_t   res_status;
    logic [31:0]        res_addr;
    logic [9:0]         res_blk;
    bpa_pkg::word_eval_t ev;

    assign limit   = (blocks_reg > LIM_MAX) ? LIM_MAX : blocks_reg;
    assign nwords  = IW'((12'(limit) + 12'd31) >> 5);
    assign accept  = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign scan_issue = (state_reg == bpa_pkg::S_SCAN) && (rd_idx_reg < nwords);
    assign end_blk    = start_reg + len_reg - 11'd1;
    assign fill_issue = (state_reg == bpa_pkg::S_FILL) && (7'(rd_idx_reg) <= 7'(end_blk[10:5]));
    assign issue      = scan_issue || fill_issue;
    assign pass_done  = !issue && !pend_reg;

    assign mem_raddr = rd_idx_reg[AW-1:0];
    assign rdata     = rvld_reg ? map_q_reg : 32'd0;
    assign wbase     = 11'({ev_idx_reg, 5'd0});
    assign ev_last   = (IW'(ev_idx_reg) == (nwords - IW'(1)));
    assign vmask     = (ev_last && (limit[4:0] != 5'd0)) ? ~(32'hFFFF_FFFF << limit[4:0])
                                                        : 32'hFFFF_FFFF;
    assign rview     = rdata | ~vmask;

    assign fill_lo = (6'(ev_idx_reg) == start_reg[10:5]) ? start_reg[4:0] : 5'd0;
    assign fill_hi = (6'(ev_idx_reg) == end_blk[10:5]) ? end_blk[4:0] : 5'd31;
    assign fmask   = (32'hFFFF_FFFF << fill_lo) & (32'hFFFF_FFFF >> (5'd31 - fill_hi));

    assign free_diff = {req.address[31:12], 12'd0} - base_reg;
    assign free_blk  = free_diff[31:12];
    assign old_bit   = tword_reg[tgt_reg[4:0]];

    bpa_word_eval u_eval (
        .resv   (rview),
        .vmask  (vmask),
        .len    (len_reg),
        .run_in (run_reg),
        .res    (ev)
    );

    assign req.ready         = (state_reg == bpa_pkg::S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.alloc_address = addr_out_reg;
    assign rsp.first_block   = blk_out_reg;
    assign rsp.free_count    = fc_out_reg;

    // result of the finished item
    always_comb
    begin
        res_status = bpa_pkg::STAT_RANGE;
        res_addr   = 32'd0;
        res_blk    = 10'd0;
        total      = 12'(cnt_reg);
        unique case (req_reg)
            bpa_pkg::REQ_ALLOC:
            begin
                if (len_reg == 11'd0)
                begin
                    res_status = bpa_pkg::STAT_ZERO_LEN;
                end
                else if (found_reg)
                begin
                    res_status = bpa_pkg::STAT_OK;
                    res_addr   = base_reg + 32'({start_reg, 12'd0});
                    res_blk    = start_reg[9:0];
                    total      = 12'(cnt_reg) + 12'(len_reg);
                end
                else
                begin
                    res_status = bpa_pkg::STAT_NO_RUN;
                end
            end
            bpa_pkg::REQ_FREE:
            begin
                if (tgt_ok_reg)
                begin
                    res_status = bpa_pkg::STAT_OK;
                    res_blk    = tgt_reg[9:0];
                    total      = 12'(cnt_reg) - 12'(old_bit);
                end
            end
            bpa_pkg::REQ_RESERVE:
            begin
                if (tgt_ok_reg)
                begin
                    res_status = bpa_pkg::STAT_OK;
                    res_blk    = tgt_reg[9:0];
                    total      = 12'(cnt_reg) + 12'(!old_bit);
                end
            end
            default:
            begin
                res_status = bpa_pkg::STAT_RANGE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = bpa_pkg::S_SCAN;
                end
            end
            bpa_pkg::S_SCAN:
            begin
                if (pass_done)
                begin
                    if (search_reg && found_reg)
                    begin
                        state_next = bpa_pkg::S_FILL;
                    end
                    else if (((req_reg == bpa_pkg::REQ_FREE) ||
                              (req_reg == bpa_pkg::REQ_RESERVE)) && tgt_ok_reg)
                    begin
                        state_next = bpa_pkg::S_UPDATE;
                    end
                    else
                    begin
                        state_next = bpa_pkg::S_FINISH;
                    end
                end
            end
            bpa_pkg::S_FILL:
            begin
                if (pass_done)
                begin
                    state_next = bpa_pkg::S_FINISH;
                end
            end
            bpa_pkg::S_UPDATE:
            begin
                state_next = bpa_pkg::S_FINISH;
            end
            bpa_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next       = req_reg;
        len_next       = len_reg;
        tgt_next       = tgt_reg;
        tgt_ok_next    = tgt_ok_reg;
        search_next    = search_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        cnt_next       = cnt_reg;
        tword_next     = tword_reg;
        rd_idx_next    = issue ? (rd_idx_reg + IW'(1)) : rd_idx_reg;
        pend_next      = issue;
        ev_idx_next    = rd_idx_reg[AW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = ev_idx_reg;
        mem_wdata      = rdata | fmask;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        addr_out_next  = addr_out_reg;
        blk_out_next   = blk_out_reg;
        fc_out_next    = fc_out_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next       = req.req_type;
                    len_next       = req.run_length;
                    search_next    = (req.req_type == bpa_pkg::REQ_ALLOC) &&
                                     (req.run_length != 11'd0);
                    found_next     = 1'b0;
                    run_next       = 12'd0;
                    run_start_next = 11'd0;
                    cnt_next       = 11'd0;
                    rd_idx_next    = '0;
                    pend_next      = 1'b0;
                    tgt_next       = 11'd0;
                    tgt_ok_next    = 1'b0;
                    if (req.req_type == bpa_pkg::REQ_FREE)
                    begin
                        tgt_next    = free_blk[10:0];
                        tgt_ok_next = free_blk < 20'(limit);
                    end
                    else if (req.req_type == bpa_pkg::REQ_RESERVE)
                    begin
                        tgt_next    = 11'(req.block_index);
                        tgt_ok_next = 11'(req.block_index) < limit;
                    end
                end
            end
            bpa_pkg::S_SCAN:
            begin
                if (pend_reg)
                begin
                    cnt_next = cnt_reg + 11'(ev.resv_cnt);
                    if (search_reg && !found_reg)
                    begin
                        if (ev.carry_hit)
                        begin
                            found_next = 1'b1;
                            start_next = run_start_reg;
                        end
                        else if (ev.win_hit)
                        begin
                            found_next = 1'b1;
                            start_next = wbase + 11'(ev.win_pos);
                        end
                    end
                    // carry the free run at the top of the word into the next
                    if (ev.all_free)
                    begin
                        run_next = run_reg + 12'd32;
                        if (run_reg == 12'd0)
                        begin
                            run_start_next = wbase;
                        end
                    end
                    else
                    begin
                        run_next       = 12'(ev.lead_free);
                        run_start_next = wbase + 11'(6'd32 - 6'(ev.lead_free));
                    end
                    if (6'(ev_idx_reg) == tgt_reg[10:5])
                    begin
                        tword_next = rdata;
                    end
                end
                if (pass_done && search_reg && found_reg)
                begin
                    rd_idx_next = IW'(start_reg[10:5]);
                end
            end
            bpa_pkg::S_FILL:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ev_idx_reg;
                    mem_wdata = rdata | fmask;
                end
            end
            bpa_pkg::S_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = tgt_reg[AW+4:5];
                if (req_reg == bpa_pkg::REQ_FREE)
                begin
                    mem_wdata = tword_reg & ~(32'd1 << tgt_reg[4:0]);
                end
                else
                begin
                    mem_wdata = tword_reg | (32'd1 << tgt_reg[4:0]);
                end
            end
            bpa_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status;
                    addr_out_next  = res_addr;
                    blk_out_next   = res_blk;
                    fc_out_next    = limit - total[10:0];
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg;
            end
        endcase
    end

    // bitmap memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        map_q_reg <= map_mem[mem_raddr];
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            map_vld_reg   <= '0;
            rvld_reg      <= 1'b0;
            blocks_reg    <= 11'd1024;
            base_reg      <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            rvld_reg      <= map_vld_reg[mem_raddr];
            if (mem_we)
            begin
                map_vld_reg[mem_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bpa_pkg::CFG_BLOCKS_IN_USE: blocks_reg <= cfg_data[10:0];
                    bpa_pkg::CFG_BASE_ADDRESS:  base_reg   <= cfg_data;
                    default:                    base_reg   <= base_reg;
                endcase
            end
        end
    end

    // item context and output payload
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        len_reg       <= len_next;
        tgt_reg       <= tgt_next;
        tgt_ok_reg    <= tgt_ok_next;
        search_reg    <= search_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        cnt_reg       <= cnt_next;
        tword_reg     <= tword_next;
        rd_idx_reg    <= rd_idx_next;
        ev_idx_reg    <= ev_idx_next;
        status_reg    <= status_next;
        addr_out_reg  <= addr_out_next;
        blk_out_reg   <= blk_out_next;
        fc_out_reg    <= fc_out_next;
    end

    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("ready stayed high after an accepted item");

    a_run_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpa_pkg::S_FILL) |-> ((12'(start_reg) + 12'(len_reg)) <= 12'(limit)))
        else $error("allocated run crosses the managed limit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpa_pkg::S_FINISH) |-> (cnt_reg <= limit))
        else $error("reserved count exceeds the managed limit");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == bpa_pkg::S_FILL) || (state_reg == bpa_pkg::S_UPDATE)))
        else $error("bitmap written outside a write phase");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == bpa_pkg::S_FINISH))
        else $error("result raised outside the finish step");

endmodule

`default_nettype wire

/* design/bpa_word_eval.sv */
// Shared scan unit: analyzes one 32-bit bitmap word per cycle for the run search
// and the reserved count. Depends on bpa_pkg.
`default_nettype none

module bpa_word_eval (
    input  logic [31:0]          resv,     // reserved view, bits past the limit set
    input  logic [31:0]          vmask,    // bits below the limit
    input  logic [10:0]          len,
    input  logic [11:0]          run_in,   // free bits ending just below this word
    output bpa_pkg::word_eval_t  res
);

    logic [31:0] p [6];
    logic [2:0]  k;
    logic [4:0]  sh;
    logic [31:0] sel;
    logic [31:0] win;
    logic [31:0] cm;
    logic [5:0]  tz;
    logic [5:0]  pc;
    logic [4:0]  lf;
    logic [4:0]  wpos;
    logic        len_small;

    always_comb
    begin
        // p[i][s]: bits s .. s+2^i-1 all free
        p[0] = ~resv;
        for (int i = 1; i < 6; i++)
        begin
            p[i] = p[i-1] & (p[i-1] >> (1 << (i - 1)));
        end

        k = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (len[i])
            begin
                k = 3'(i);
            end
        end
        sh  = 5'(len[5:0] - (6'd1 << k));
        sel = p[k];
        // two overlapping power-of-two windows cover the full length
        win = sel & (sel >> sh);
        len_small = (len != 11'd0) && (len <= 11'd32);

        wpos = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (win[i])
            begin
                wpos = 5'(i);
            end
        end

        tz = 6'd32;
        for (int i = 31; i >= 0; i--)
        begin
            if (resv[i])
            begin
                tz = 6'(i);
            end
        end

        lf = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (resv[i])
            begin
                lf = 5'(31 - i);
            end
        end

        cm = resv & vmask;
        pc = '0;
        for (int i = 0; i < 32; i++)
        begin
            pc = pc + 6'(cm[i]);
        end

        res.carry_hit = (run_in != 12'd0) && ((13'(run_in) + 13'(tz)) >= 13'(len));
        res.win_hit   = len_small && (win != 32'd0);
        res.win_pos   = wpos;
        res.all_free  = (resv == 32'd0);
        res.lead_free = lf;
        res.resv_cnt  = pc;
    end

endmodule

`default_nettype wire
